/* rtl/core/bpss_pkg.sv */
// bpss_pkg: shared types and constants for the bucket prefix sum sampler
// no dependencies; used by bpss_step, bpss_rsq and the top level

package bpss_pkg;

    // fixed field widths of the result transaction
    localparam int unsigned CountW  = 32;
    localparam int unsigned BorderW = 32;
    localparam int unsigned SampleW = 40;
    localparam int unsigned IndexW  = 32;

    // result queue geometry
    localparam int unsigned RsqDepth = 4;
    localparam int unsigned RsqPtrW  = 2;
    localparam int unsigned RsqCntW  = 3;

    typedef struct packed {
        logic [BorderW-1:0] border_low;
        logic               sample_valid;
        logic [SampleW-1:0] sample_value;
        logic               change_valid;
        logic [IndexW-1:0]  change_index;
        logic [CountW-1:0]  max_count;
        logic               run_last;
    } t_result;

    // handoff from the step logic to the result queue
    typedef struct packed {
        logic    push;
        logic    push_two;
        t_result res0;
        t_result res1;
    } t_push;

endpackage

/* rtl/core/bpss_step.sv */
// bpss_step: run state, configuration register and the per-item update
// depends on bpss_pkg

module bpss_step #(
    parameter int unsigned LOW_BITS         = 32,
    parameter int unsigned SUM_BITS         = 40,
    parameter int unsigned MAX_SAMPLE_SHIFT = 9
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bpss_pkg::CountW-1:0]        i_cfg_data,
    input  logic                               i_adv,
    input  logic [bpss_pkg::CountW-1:0]        i_count,
    output bpss_pkg::t_push                    o_push
);

    localparam int unsigned HiW   = SUM_BITS - LOW_BITS;
    localparam int unsigned NcmW  = HiW + 1;
    localparam logic [NcmW-1:0] NcmLimit = NcmW'(1) << HiW;
    localparam logic [NcmW-1:0] NcmOne   = NcmW'(1);

    logic [SUM_BITS-1:0]         r_total;
    logic [bpss_pkg::CountW-1:0] r_max;
    logic [bpss_pkg::IndexW-1:0] r_idx;
    logic [NcmW-1:0]             r_ncm;
    logic [SUM_BITS-1:0]         r_last_smp;
    logic [bpss_pkg::CountW-1:0] r_num_codes;
    logic [MAX_SAMPLE_SHIFT-1:0] r_smp_mask;

    logic [MAX_SAMPLE_SHIFT-1:0] n_smp_mask;
    logic                        first;
    logic [SUM_BITS-1:0]         base_total;
    logic [bpss_pkg::CountW-1:0] base_max;
    logic [NcmW-1:0]             base_ncm;
    logic [SUM_BITS-1:0]         base_ls;
    logic [bpss_pkg::CountW-1:0] n_max;
    logic [SUM_BITS:0]           sum_w;
    logic [SUM_BITS-1:0]         tot;
    logic                        chg;
    logic                        smp;
    logic [SUM_BITS-1:0]         ls_new;
    logic                        last;
    logic                        final_smp;

    // sample mask bit k is set when 2^(k+1) is still below the code count
    always_comb begin
        for (int k = 0; k < MAX_SAMPLE_SHIFT; k++) begin
            n_smp_mask[k] = {1'b0, i_cfg_data} > (33'd1 << (k + 1));
        end
    end

    always_comb begin
        first      = (r_idx == '0);
        base_total = first ? '0 : r_total;
        base_max   = first ? '0 : r_max;
        base_ncm   = first ? NcmOne : r_ncm;
        base_ls    = first ? '0 : r_last_smp;

        n_max = (i_count > base_max) ? i_count : base_max;

        // saturating accumulate
        sum_w = {1'b0, base_total} + (SUM_BITS + 1)'(i_count);
        tot   = sum_w[SUM_BITS] ? '1 : sum_w[SUM_BITS-1:0];

        chg = !first && (base_ncm < NcmLimit)
            && ({1'b0, tot[SUM_BITS-1:LOW_BITS]} >= base_ncm);

        smp    = ((r_idx[MAX_SAMPLE_SHIFT-1:0] & r_smp_mask) == '0);
        ls_new = smp ? tot : base_ls;

        last      = ({1'b0, r_idx} + 33'd1) >= {1'b0, r_num_codes};
        final_smp = tot > ls_new;

        o_push.push     = i_adv;
        o_push.push_two = last;

        o_push.res0.border_low   = bpss_pkg::BorderW'(tot[LOW_BITS-1:0]);
        o_push.res0.sample_valid = smp;
        o_push.res0.sample_value = smp ? bpss_pkg::SampleW'(tot) : '0;
        o_push.res0.change_valid = chg;
        o_push.res0.change_index = chg ? (r_idx - 32'd1) : '0;
        o_push.res0.max_count    = n_max;
        o_push.res0.run_last     = 1'b0;

        o_push.res1.border_low   = bpss_pkg::BorderW'(tot[LOW_BITS-1:0]);
        o_push.res1.sample_valid = final_smp;
        o_push.res1.sample_value = final_smp ? bpss_pkg::SampleW'(tot) : '0;
        o_push.res1.change_valid = 1'b0;
        o_push.res1.change_index = '0;
        o_push.res1.max_count    = n_max;
        o_push.res1.run_last     = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_max       <= '0;
            r_idx       <= '0;
            r_ncm       <= NcmOne;
            r_last_smp  <= '0;
            r_num_codes <= 32'd2;
            r_smp_mask  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_num_codes <= i_cfg_data;
                r_smp_mask  <= n_smp_mask;
            end
            if (i_adv) begin
                if (last) begin
                    r_total    <= '0;
                    r_max      <= '0;
                    r_idx      <= '0;
                    r_ncm      <= NcmOne;
                    r_last_smp <= '0;
                end else begin
                    r_total    <= tot;
                    r_max      <= n_max;
                    r_idx      <= r_idx + 32'd1;
                    r_ncm      <= chg ? (base_ncm + NcmOne) : base_ncm;
                    r_last_smp <= ls_new;
                end
            end
        end
    end

endmodule

/* rtl/core/bpss_rsq.sv */
// bpss_rsq: small result queue, takes one or two results per cycle, gives one
// depends on bpss_pkg

module bpss_rsq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bpss_pkg::t_push   i_push,
    input  logic              i_pop,
    output logic              o_room,
    output logic              o_valid,
    output bpss_pkg::t_result o_res
);

    bpss_pkg::t_result r_mem [bpss_pkg::RsqDepth];
    logic [bpss_pkg::RsqPtrW-1:0] r_wr;
    logic [bpss_pkg::RsqPtrW-1:0] r_rd;
    logic [bpss_pkg::RsqCntW-1:0] r_cnt;
    logic [bpss_pkg::RsqCntW-1:0] push_n;
    logic                         pop_ok;

    assign o_valid = (r_cnt != '0);
    assign o_res   = r_mem[r_rd];
    assign pop_ok  = i_pop && o_valid;
    // room for a two-result transaction regardless of the pop
    assign o_room  = (r_cnt <= bpss_pkg::RsqCntW'(bpss_pkg::RsqDepth - 2));

    always_comb begin
        push_n = '0;
        if (i_push.push) begin
            push_n = i_push.push_two ? 3'd2 : 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr] <= i_push.res0;
            if (i_push.push_two) begin
                r_mem[r_wr + 2'd1] <= i_push.res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + bpss_pkg::RsqPtrW'(push_n);
            r_rd  <= r_rd + {1'b0, pop_ok};
            r_cnt <= r_cnt + push_n - {2'b0, pop_ok};
        end
    end

endmodule

/* rtl/core/bucket_prefix_sum_sampler_top.sv */
// bucket_prefix_sum_sampler_top: running prefix sum with border entries,
// sampling, change points and run maximum; uses bpss_pkg, bpss_step, bpss_rsq
//
// channel | direction | handshake                  | payload
// --------+-----------+----------------------------+-------------------------------
// in      | input     | i_in_valid / o_in_stall    | i_bucket_count
// out     | output    | o_out_valid / i_out_stall  | o_border_low .. o_run_last
// cfg     | input     | i_cfg_we (no wait)         | i_cfg_data (num_codes)
//
// one count transaction per cycle while the queue has room; it is held in
// the input register and its results are then presented by the result queue
// the last item of a run yields two results, taking an extra queue entry;
// the input stalls only while the four-entry result queue lacks room
// reset is synchronous and active low; it clears the run state and the queue
// and sets num_codes to 2; output stall backs up through the queue

module bucket_prefix_sum_sampler_top #(
    parameter int unsigned LOW_BITS         = 32,
    parameter int unsigned SUM_BITS         = 40,
    parameter int unsigned MAX_SAMPLE_SHIFT = 9
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [bpss_pkg::CountW-1:0]   i_cfg_data,
    // count input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [bpss_pkg::CountW-1:0]   i_bucket_count,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [bpss_pkg::BorderW-1:0]  o_border_low,
    output logic                          o_sample_valid,
    output logic [bpss_pkg::SampleW-1:0]  o_sample_value,
    output logic                          o_change_valid,
    output logic [bpss_pkg::IndexW-1:0]   o_change_index,
    output logic [bpss_pkg::CountW-1:0]   o_max_count,
    output logic                          o_run_last
);

    // input register
    logic                        r_in_vld;
    logic [bpss_pkg::CountW-1:0] r_in_count;

    logic              room;
    logic              adv;
    logic              in_take;
    bpss_pkg::t_push   push;
    bpss_pkg::t_result res;

    // the held item moves into the queue when there is room for two results
    assign adv        = r_in_vld && room;
    assign o_in_stall = r_in_vld && !room;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_count <= i_bucket_count;
        end
    end

    // run state and the per-item arithmetic
    bpss_step #(
        .LOW_BITS         (LOW_BITS),
        .SUM_BITS         (SUM_BITS),
        .MAX_SAMPLE_SHIFT (MAX_SAMPLE_SHIFT)
    ) u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_adv      (adv),
        .i_count    (r_in_count),
        .o_push     (push)
    );

    // result queue decouples output stalls from the input side
    bpss_rsq u_rsq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (!i_out_stall),
        .o_room  (room),
        .o_valid (o_out_valid),
        .o_res   (res)
    );

    assign o_border_low   = res.border_low;
    assign o_sample_valid = res.sample_valid;
    assign o_sample_value = res.sample_value;
    assign o_change_valid = res.change_valid;
    assign o_change_index = res.change_index;
    assign o_max_count    = res.max_count;
    assign o_run_last     = res.run_last;

endmodule

/* rtl/core/bpss_chk.sv */
// bpss_chk: port-level checks for the sampler top level, attached by bind
// depends on bpss_pkg and bucket_prefix_sum_sampler_top

module bpss_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [bpss_pkg::BorderW-1:0]  o_border_low,
    input logic                          o_sample_valid,
    input logic [bpss_pkg::SampleW-1:0]  o_sample_value,
    input logic                          o_change_valid,
    input logic [bpss_pkg::IndexW-1:0]   o_change_index,
    input logic                          o_run_last
);

    // the closing result of a run never carries a change point
    a_last_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_run_last |-> !o_change_valid)
        else $error("change point on final result");

    // sample value is zero when no sample is carried
    a_sample_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_sample_valid |-> o_sample_value == '0)
        else $error("sample value without sample");

    // change index is zero when no change point is carried
    a_change_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_change_valid |-> o_change_index == '0)
        else $error("change index without change point");

    // a stalled result stays offered, with border, sample value and run-last flag unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_border_low)
            && $stable(o_sample_value) && $stable(o_run_last))
        else $error("stalled result changed");

endmodule

bind bucket_prefix_sum_sampler_top bpss_chk u_bpss_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_border_low   (o_border_low),
    .o_sample_valid (o_sample_valid),
    .o_sample_value (o_sample_value),
    .o_change_valid (o_change_valid),
    .o_change_index (o_change_index),
    .o_run_last     (o_run_last)
);
